>>> rtl/ldce_pkg.sv
// Shared types, codes and constants for the list DMA copy and fill engine.
package ldce_pkg;

    // Default sizes.
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Field widths.
    localparam int ADDR_BITS = 24;
    localparam int DATA_BITS = 8;
    localparam int VER_BITS  = 2;

    // Bus operations.
    localparam logic [1:0] OP_MEM_WR = 2'd0;
    localparam logic [1:0] OP_MEM_RD = 2'd1;
    localparam logic [1:0] OP_REG_WR = 2'd2;
    localparam logic [1:0] OP_REG_RD = 2'd3;

    // DMA register indexes.
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_HIGH  = 2'd1;
    localparam logic [1:0] REG_BANK  = 2'd2;

    // Work kinds passed from the front end to the back end.
    localparam logic [1:0] KIND_WR    = 2'd0;
    localparam logic [1:0] KIND_RD    = 2'd1;
    localparam logic [1:0] KIND_JOB   = 2'd2;
    localparam logic [1:0] KIND_CONST = 2'd3;

    // Job list commands.
    localparam logic [7:0] CMD_COPY      = 8'h00;
    localparam logic [7:0] CMD_FILL      = 8'h03;
    localparam logic [7:0] CMD_COPY_DOWN = 8'h30;

    // Misc constants.
    localparam logic [7:0]          REG_READ_VALUE = 8'h7f;
    localparam logic [7:0]          WRITE_RESULT   = 8'h00;
    localparam int                  DIR_BIT        = 22;
    localparam logic [3:0]          LIST_BYTES     = 4'd9;
    localparam logic [VER_BITS-1:0] VERSION_LEGACY = 2'd1;
    localparam logic [VER_BITS-1:0] VERSION_RESET  = 2'd2;

    // One queued unit of work.
    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
    } t_q_entry;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/ldce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ldce_ram #(
    parameter int DATA_BITS = ldce_pkg::DATA_BITS,
    parameter int DEPTH     = 1 << ldce_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_BITS-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_BITS-1:0]     o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ldce_fifo.sv
// Short register queue between the front end and the back end.
module ldce_fifo #(
    parameter int WIDTH = $bits(ldce_pkg::t_q_entry),
    parameter int DEPTH = ldce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output ldce_pkg::t_q_status   o_status
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_status.empty = (r_count == '0);

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue popped while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/ldce_front.sv
// Front end: accepts bus items, keeps the list address bytes and classifies work.
module ldce_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic [ldce_pkg::ADDR_BITS-1:0]      i_address,
    input  logic [ldce_pkg::DATA_BITS-1:0]      i_write_data,
    input  ldce_pkg::t_q_status                 i_q_status,
    input  logic                                i_clearing,
    output logic                                o_push,
    output ldce_pkg::t_q_entry                  o_entry
);

    logic [7:0] r_list_high, n_list_high;
    logic [7:0] r_list_bank, n_list_bank;

    // Items are taken while the queue has room and the memory is not being cleared.
    assign o_in_ready = !i_q_status.full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    // Classify the item and latch the list address bytes.
    always_comb begin
        n_list_high   = r_list_high;
        n_list_bank   = r_list_bank;
        o_entry.kind  = ldce_pkg::KIND_CONST;
        o_entry.addr  = i_address;
        o_entry.data  = ldce_pkg::WRITE_RESULT;
        case (i_operation)
            ldce_pkg::OP_MEM_WR: begin
                o_entry.kind = ldce_pkg::KIND_WR;
                o_entry.data = i_write_data;
            end
            ldce_pkg::OP_MEM_RD: begin
                o_entry.kind = ldce_pkg::KIND_RD;
            end
            ldce_pkg::OP_REG_WR: begin
                case (i_address[1:0])
                    ldce_pkg::REG_START: begin
                        o_entry.kind = ldce_pkg::KIND_JOB;
                        o_entry.addr = {r_list_bank, r_list_high, i_write_data};
                    end
                    ldce_pkg::REG_HIGH: begin
                        if (o_push) begin
                            n_list_high = i_write_data;
                        end
                    end
                    ldce_pkg::REG_BANK: begin
                        if (o_push) begin
                            n_list_bank = i_write_data;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                o_entry.data = ldce_pkg::REG_READ_VALUE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_high <= '0;
            r_list_bank <= '0;
        end else begin
            r_list_high <= n_list_high;
            r_list_bank <= n_list_bank;
        end
    end

endmodule

>>> rtl/ldce_back.sv
// Back end: owns the byte memory, runs bus accesses and DMA jobs, holds the result register.
module ldce_back #(
    parameter int MEM_ADDR_BITS = ldce_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ldce_pkg::VER_BITS-1:0]       i_cfg_wr_data,
    input  ldce_pkg::t_q_status                 i_q_status,
    input  ldce_pkg::t_q_entry                  i_q_entry,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ldce_pkg::DATA_BITS-1:0]      o_read_data
);

    localparam int AW = ldce_pkg::ADDR_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_LIST   = 3'd2;
    localparam logic [2:0] S_SETUP  = 3'd3;
    localparam logic [2:0] S_MVRD   = 3'd4;
    localparam logic [2:0] S_MVWR   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                      r_state, n_state;
    logic                            r_clearing, n_clearing;
    logic [MEM_ADDR_BITS-1:0]        r_clr_addr, n_clr_addr;
    logic                            r_out_valid, n_out_valid;
    logic [7:0]                      r_out_data, n_out_data;
    logic [ldce_pkg::VER_BITS-1:0]   r_version, n_version;
    logic [AW-1:0]                   r_ptr, n_ptr;
    logic [3:0]                      r_lidx, n_lidx;
    logic [71:0]                     r_ent, n_ent;
    logic [15:0]                     r_len, n_len;
    logic [AW-1:0]                   r_src, n_src;
    logic [AW-1:0]                   r_dst, n_dst;
    logic                            r_src_dn, n_src_dn;
    logic                            r_dst_dn, n_dst_dn;
    logic                            r_fill, n_fill;

    logic                            out_free;
    logic                            op_we;
    logic [AW-1:0]                   op_waddr;
    logic [7:0]                      op_wdata;
    logic [AW-1:0]                   op_raddr;
    logic                            ram_we;
    logic [MEM_ADDR_BITS-1:0]        ram_waddr;
    logic [7:0]                      ram_wdata;
    logic [7:0]                      ram_rdata;
    logic [7:0]                      ent_cmd;
    logic [15:0]                     ent_len;
    logic [AW-1:0]                   ent_src;
    logic [AW-1:0]                   ent_dst;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = (r_state == S_IDLE) && !r_clearing && !i_q_status.empty && out_free;

    // List entry fields, first byte in the low bits.
    assign ent_cmd = r_ent[7:0];
    assign ent_len = r_ent[23:8];
    assign ent_src = r_ent[47:24];
    assign ent_dst = r_ent[71:48];

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clearing  = r_clearing;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_version   = i_cfg_wr_en ? i_cfg_wr_data : r_version;
        n_ptr       = r_ptr;
        n_lidx      = r_lidx;
        n_ent       = r_ent;
        n_len       = r_len;
        n_src       = r_src;
        n_dst       = r_dst;
        n_src_dn    = r_src_dn;
        n_dst_dn    = r_dst_dn;
        n_fill      = r_fill;
        op_we       = 1'b0;
        op_waddr    = r_dst;
        op_wdata    = r_fill ? ent_src[7:0] : ram_rdata;
        op_raddr    = r_src;

        // Clearing pass after reset, one byte a cycle.
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                n_clearing = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_q_entry.kind)
                        ldce_pkg::KIND_WR: begin
                            op_we       = 1'b1;
                            op_waddr    = i_q_entry.addr;
                            op_wdata    = i_q_entry.data;
                            n_out_valid = 1'b1;
                            n_out_data  = ldce_pkg::WRITE_RESULT;
                        end
                        ldce_pkg::KIND_RD: begin
                            op_raddr = i_q_entry.addr;
                            n_state  = S_RDWAIT;
                        end
                        ldce_pkg::KIND_JOB: begin
                            n_ptr   = i_q_entry.addr;
                            n_lidx  = '0;
                            n_state = S_LIST;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = i_q_entry.data;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = ram_rdata;
                n_state     = S_IDLE;
            end
            S_LIST: begin
                // Each read is issued in the cycle before its byte is captured.
                op_raddr = r_ptr + AW'(r_lidx);
                if (r_lidx != '0) begin
                    n_ent = {ram_rdata, r_ent[71:8]};
                end
                n_lidx = r_lidx + 1'b1;
                if (r_lidx == ldce_pkg::LIST_BYTES) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_len    = ent_len;
                n_src    = ent_src;
                n_dst    = ent_dst;
                n_src_dn = 1'b0;
                n_dst_dn = 1'b0;
                n_fill   = 1'b0;
                n_state  = S_MVRD;
                case (ent_cmd)
                    ldce_pkg::CMD_COPY: begin
                        if (r_version == ldce_pkg::VERSION_LEGACY) begin
                            if (!ent_src[ldce_pkg::DIR_BIT] && ent_dst[ldce_pkg::DIR_BIT]) begin
                                n_dst[ldce_pkg::DIR_BIT] = 1'b0;
                                n_dst_dn = 1'b1;
                            end else if (ent_src[ldce_pkg::DIR_BIT]
                                         && !ent_dst[ldce_pkg::DIR_BIT]) begin
                                n_src[ldce_pkg::DIR_BIT] = 1'b0;
                                n_src_dn = 1'b1;
                            end else if (ent_src[ldce_pkg::DIR_BIT]) begin
                                // Both steer bits set: step down before each use.
                                n_src = {ent_src[AW-1:ldce_pkg::DIR_BIT+1], 1'b0,
                                         ent_src[ldce_pkg::DIR_BIT-1:0]} - 1'b1;
                                n_dst = {ent_dst[AW-1:ldce_pkg::DIR_BIT+1], 1'b0,
                                         ent_dst[ldce_pkg::DIR_BIT-1:0]} - 1'b1;
                                n_src_dn = 1'b1;
                                n_dst_dn = 1'b1;
                            end
                        end
                    end
                    ldce_pkg::CMD_FILL: begin
                        n_fill  = 1'b1;
                        n_state = S_MVWR;
                    end
                    ldce_pkg::CMD_COPY_DOWN: begin
                        n_src_dn = 1'b1;
                        n_dst_dn = 1'b1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
                if (ent_len == '0) begin
                    n_state = S_DONE;
                end
            end
            S_MVRD: begin
                op_raddr = r_src;
                n_state  = S_MVWR;
            end
            S_MVWR: begin
                op_we   = 1'b1;
                n_src   = r_src_dn ? r_src - 1'b1 : r_src + 1'b1;
                n_dst   = r_dst_dn ? r_dst - 1'b1 : r_dst + 1'b1;
                n_len   = r_len - 1'b1;
                if (r_len == 16'd1) begin
                    n_state = S_DONE;
                end else if (!r_fill) begin
                    n_state = S_MVRD;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_data  = ldce_pkg::WRITE_RESULT;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory port selection; the clearing pass owns the write port.
    assign ram_we    = r_clearing || op_we;
    assign ram_waddr = r_clearing ? r_clr_addr : op_waddr[MEM_ADDR_BITS-1:0];
    assign ram_wdata = r_clearing ? 8'h00 : op_wdata;

    ldce_ram #(
        .DATA_BITS (8),
        .DEPTH     (1 << MEM_ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (op_raddr[MEM_ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_version   <= ldce_pkg::VERSION_RESET;
        end else begin
            r_state     <= n_state;
            r_clearing  <= n_clearing;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_version   <= n_version;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_ptr      <= n_ptr;
        r_lidx     <= n_lidx;
        r_ent      <= n_ent;
        r_len      <= n_len;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_src_dn   <= n_src_dn;
        r_dst_dn   <= n_dst_dn;
        r_fill     <= n_fill;
    end

    assign o_clearing  = r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

`ifndef NO_ASSERTIONS
    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_clearing)
        else $error("work taken during the clearing pass");
    a_done_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE || r_state == S_RDWAIT) |-> !r_out_valid)
        else $error("result register busy when a result is due");
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_we |-> (r_state == S_IDLE || r_state == S_MVWR))
        else $error("memory write from an unexpected state");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE && r_out_valid))
        else $error("job end did not post its result");
`endif

endmodule

>>> rtl/list_dma_copy_fill_engine_top.sv
// Top level of the list DMA copy and fill engine.
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_ready        i_operation, i_address, i_write_data
//  result    out        o_out_valid / i_out_ready      o_read_data
//  config    in         i_cfg_wr_en (no wait)          i_cfg_wr_data (engine version)
//
// A memory write or a register access that starts no job loads the result register as it
// leaves the queue, a read once the RAM data is registered; the sequencer sets the pace.
// A job fetches its nine-byte list entry and decodes it, then reads and writes each byte
// copied or writes each byte filled, then posts its result; a zero length moves no byte.
// After reset a clearing pass zeroes the memory, during which
// no item is taken; configuration writes are taken at any time.
// The queue lets the input side keep taking items while a result waits or a job runs.
module list_dma_copy_fill_engine_top #(
    parameter int MEM_ADDR_BITS = ldce_pkg::MEM_ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH   = ldce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ldce_pkg::VER_BITS-1:0]       i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic [ldce_pkg::ADDR_BITS-1:0]      i_address,
    input  logic [ldce_pkg::DATA_BITS-1:0]      i_write_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ldce_pkg::DATA_BITS-1:0]      o_read_data
);

    localparam int QW = $bits(ldce_pkg::t_q_entry);

    ldce_pkg::t_q_status w_q_status;
    ldce_pkg::t_q_entry  w_push_entry;
    ldce_pkg::t_q_entry  w_head_entry;
    logic [QW-1:0]       w_head_bits;
    logic                w_push;
    logic                w_pop;
    logic                w_clearing;

    ldce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_q_status   (w_q_status),
        .i_clearing   (w_clearing),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    ldce_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_entry),
        .i_pop    (w_pop),
        .o_data   (w_head_bits),
        .o_status (w_q_status)
    );

    assign w_head_entry = ldce_pkg::t_q_entry'(w_head_bits);

    ldce_back #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_status    (w_q_status),
        .i_q_entry     (w_head_entry),
        .o_pop         (w_pop),
        .o_clearing    (w_clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data)
    );

endmodule
